// ===== hdl/btlca_pkg.sv =====
// types and status codes shared by the block tree common-ancestor engine
`timescale 1ns / 1ps

package btlca_pkg;

    // block ids are carried as fixed 8-bit fields
    localparam int BLOCK_W = 8;

    // request codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_SAME    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [BLOCK_W-1:0] first_block;
        logic [BLOCK_W-1:0] second_block;
    } req_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] ancestor_block;
        logic [1:0]         status;
    } rsp_t;

endpackage

// ===== hdl/block_tree_lca_engine.sv =====
// Block tree lowest common ancestor engine: node table, block map and walk sequencer.
//
// Requests arrive on req/req_valid/req_ready and each gives exactly one
// response on rsp/rsp_valid/rsp_ready. A request is either an add (append
// second_block as a child of first_block, creating the root for block 0 on
// the first add) or a query (return the block id of the lowest common
// ancestor of the two blocks).
// One request is worked on at a time: req_ready is high only while the
// sequencer is idle, and the response stays in its output register until
// the receiver takes it, so a stalled receiver simply holds the engine.
// An add passes S_RDA and S_ADD, with S_ROOT before them on the very
// first add, which also writes the root node. A query passes S_RDA, S_RDB
// and S_QCHK (and answers from there when either block is unknown), then
// walks up by parent steps (at most the sum of the two nodes' depths);
// each step is one registered read of the node table followed by an index
// update, and the map lookups use the one read port of the block map, one
// block per cycle.
// Reset clears the node count and the map's present bits at once; the node
// table and the map data need no clearing.
`timescale 1ns / 1ps

module block_tree_lca_engine #(
    parameter int NODE_SLOTS = 64,
    parameter int BLOCK_IDS  = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  btlca_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output btlca_pkg::rsp_t  rsp
);

    import btlca_pkg::*;

    localparam int NW        = $clog2(NODE_SLOTS);
    localparam int CW        = $clog2(NODE_SLOTS + 1);
    localparam int MAP_DEPTH = (BLOCK_IDS < (1 << BLOCK_W)) ? BLOCK_IDS : (1 << BLOCK_W);
    localparam int MW        = $clog2(MAP_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_ROOT = 10'b00_0000_0010,
        S_RDA  = 10'b00_0000_0100,
        S_ADD  = 10'b00_0000_1000,
        S_RDB  = 10'b00_0001_0000,
        S_QCHK = 10'b00_0010_0000,
        S_WALK = 10'b00_0100_0000,
        S_STEP = 10'b00_1000_0000,
        S_FIN  = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    // control state
    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [MAP_DEPTH-1:0]   map_valid_reg, map_valid_next;

    // payload state
    req_t                   req_reg, req_next;
    rsp_t                   rsp_reg, rsp_next;
    logic [NW-1:0]          a_reg, a_next;
    logic [NW-1:0]          b_reg, b_next;
    logic                   a_ok_reg, a_ok_next;
    logic                   move_a_reg, move_a_next;

    // block map memory
    logic [NW-1:0]          map_mem [MAP_DEPTH];
    logic                   map_we;
    logic [MW-1:0]          map_waddr;
    logic [NW-1:0]          map_wdata;
    logic [MW-1:0]          map_raddr;
    logic [NW-1:0]          map_rd_reg;

    // node table memories
    logic [NW-1:0]          parent_mem [NODE_SLOTS];
    logic [BLOCK_W-1:0]     blk_mem [NODE_SLOTS];
    logic                   node_we;
    logic [NW-1:0]          node_waddr;
    logic [NW-1:0]          node_wparent;
    logic [BLOCK_W-1:0]     node_wblk;
    logic [NW-1:0]          node_raddr;
    logic [NW-1:0]          parent_rd_reg;
    logic [BLOCK_W-1:0]     blk_rd_reg;

    // lookup qualifiers
    logic                   first_in_range;
    logic                   second_in_range;
    logic                   first_known;
    logic                   second_known;

    assign first_in_range  = 16'(req_reg.first_block) < 16'(BLOCK_IDS);
    assign second_in_range = 16'(req_reg.second_block) < 16'(BLOCK_IDS);
    assign first_known     = first_in_range && map_valid_reg[req_reg.first_block[MW-1:0]];
    assign second_known    = second_in_range && map_valid_reg[req_reg.second_block[MW-1:0]];

    // handshake outputs
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);
    assign rsp       = rsp_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        map_valid_next = map_valid_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        a_ok_next      = a_ok_reg;
        move_a_next    = move_a_reg;
        map_we         = 1'b0;
        map_waddr      = req_reg.second_block[MW-1:0];
        map_wdata      = count_reg[NW-1:0];
        map_raddr      = req_reg.first_block[MW-1:0];
        node_we        = 1'b0;
        node_waddr     = count_reg[NW-1:0];
        node_wparent   = map_rd_reg;
        node_wblk      = req_reg.second_block;
        node_raddr     = a_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    if (req.operation == OP_ADD && count_reg == '0)
                        state_next = S_ROOT;
                    else
                        state_next = S_RDA;
                end
            end
            // root node for block 0
            S_ROOT:
            begin
                map_we            = 1'b1;
                map_waddr         = '0;
                map_wdata         = '0;
                map_valid_next[0] = 1'b1;
                node_we           = 1'b1;
                node_waddr        = '0;
                node_wparent      = '0;
                node_wblk         = '0;
                count_next        = CW'(1);
                state_next        = S_RDA;
            end
            // look up first block
            S_RDA:
            begin
                map_raddr  = req_reg.first_block[MW-1:0];
                state_next = (req_reg.operation == OP_QUERY) ? S_RDB : S_ADD;
            end
            // checks and append
            S_ADD:
            begin
                rsp_next.ancestor_block = '0;
                if (req_reg.first_block == req_reg.second_block)
                    rsp_next.status = ST_SAME;
                else if (!first_known || !second_in_range)
                    rsp_next.status = ST_UNKNOWN;
                else if (count_reg == CW'(NODE_SLOTS))
                    rsp_next.status = ST_FULL;
                else
                begin
                    rsp_next.status = ST_OK;
                    node_we         = 1'b1;
                    map_we          = 1'b1;
                    map_valid_next[req_reg.second_block[MW-1:0]] = 1'b1;
                    count_next      = count_reg + CW'(1);
                end
                state_next = S_DONE;
            end
            // look up second block
            S_RDB:
            begin
                a_next     = map_rd_reg;
                a_ok_next  = first_known;
                map_raddr  = req_reg.second_block[MW-1:0];
                state_next = S_QCHK;
            end
            S_QCHK:
            begin
                b_next = map_rd_reg;
                if (!a_ok_reg || !second_known)
                begin
                    rsp_next.ancestor_block = '0;
                    rsp_next.status         = ST_UNKNOWN;
                    state_next              = S_DONE;
                end
                else
                    state_next = S_WALK;
            end
            // read the deeper-indexed node, or the meeting node
            S_WALK:
            begin
                if (a_reg == b_reg)
                begin
                    node_raddr = a_reg;
                    state_next = S_FIN;
                end
                else if (a_reg > b_reg)
                begin
                    node_raddr  = a_reg;
                    move_a_next = 1'b1;
                    state_next  = S_STEP;
                end
                else
                begin
                    node_raddr  = b_reg;
                    move_a_next = 1'b0;
                    state_next  = S_STEP;
                end
            end
            // move that side up to its parent
            S_STEP:
            begin
                if (move_a_reg)
                    a_next = parent_rd_reg;
                else
                    b_next = parent_rd_reg;
                state_next = S_WALK;
            end
            S_FIN:
            begin
                rsp_next.ancestor_block = blk_rd_reg;
                rsp_next.status         = ST_OK;
                state_next              = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            map_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            map_valid_reg <= map_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        a_ok_reg   <= a_ok_next;
        move_a_reg <= move_a_next;
    end

    // block map memory
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        map_rd_reg <= map_mem[map_raddr];
    end

    // node table memories
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            parent_mem[node_waddr] <= node_wparent;
            blk_mem[node_waddr]    <= node_wblk;
        end
        parent_rd_reg <= parent_mem[node_raddr];
        blk_rd_reg    <= blk_mem[node_raddr];
    end

    // node count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NODE_SLOTS))
        else $error("node count beyond table size");

    // an append only happens with room in the table
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        node_we && state_reg == S_ADD |-> count_reg < CW'(NODE_SLOTS))
        else $error("append into a full node table");

    // every walk step moves to a strictly smaller index
    a_walk_down: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |->
            (move_a_reg ? parent_rd_reg < a_reg : parent_rd_reg < b_reg))
        else $error("parent index not below child index");

    // the walk only starts on two present nodes
    a_walk_nodes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> (NW+1)'(a_reg) < (NW+1)'(count_reg)
            && (NW+1)'(b_reg) < (NW+1)'(count_reg))
        else $error("walk on a node beyond the node count");

endmodule

// ===== test/tb_block_tree_lca_engine.sv =====
// self-checking testbench for the block tree common-ancestor engine
`timescale 1ns / 1ps

module tb_block_tree_lca_engine;

    import btlca_pkg::*;

    localparam int NODE_SLOTS     = 64;
    localparam int BLOCK_IDS      = 256;
    localparam int RANDOM_ITEMS   = 470;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 300;
    localparam int LONG_HOLD      = 400;
    localparam int LONG_HOLD_AT   = 150;

    typedef struct {
        req_t payload;
        bit   drain_first;
    } pending_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // predicted engine state
    logic [5:0]  tree_parent [NODE_SLOTS];
    logic [7:0]  tree_block  [NODE_SLOTS];
    bit          map_present [BLOCK_IDS];
    logic [6:0]  map_node    [BLOCK_IDS];
    int unsigned tree_nodes = 0;

    rsp_t     lca_expected [$];
    pending_t pending_reqs [$];

    // generation-side view of which blocks exist, used only to shape stimulus
    bit         gen_known [BLOCK_IDS];
    logic [7:0] gen_known_list [$];
    int         gen_nodes = 0;
    logic [7:0] gen_last_child = 8'd0;

    int total_reqs     = 0;
    int sent_count     = 0;
    int got_count      = 0;
    int mismatch_count = 0;
    int drive_gap      = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    block_tree_lca_engine #(
        .NODE_SLOTS(NODE_SLOTS),
        .BLOCK_IDS (BLOCK_IDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #5 clk = ~clk;

    // expected response of one request, updating the predicted tree
    function automatic rsp_t lca_predict(req_t r);
        rsp_t res;
        int   a;
        int   b;
        int   guard;
        res.ancestor_block = '0;
        res.status = ST_OK;
        if (r.operation == OP_ADD)
        begin
            // root appears on the first add, whatever its outcome
            if (tree_nodes == 0)
            begin
                tree_parent[0] = '0;
                tree_block[0]  = '0;
                map_present[0] = 1'b1;
                map_node[0]    = '0;
                tree_nodes     = 1;
            end
            if (r.first_block == r.second_block)
                res.status = ST_SAME;
            else if (!map_present[r.first_block])
                res.status = ST_UNKNOWN;
            else if (tree_nodes >= NODE_SLOTS)
                res.status = ST_FULL;
            else
            begin
                tree_parent[tree_nodes]     = map_node[r.first_block][5:0];
                tree_block[tree_nodes]      = r.second_block;
                map_present[r.second_block] = 1'b1;
                map_node[r.second_block]    = tree_nodes[6:0];
                tree_nodes                  = tree_nodes + 1;
            end
        end
        else if (!map_present[r.first_block] || !map_present[r.second_block])
            res.status = ST_UNKNOWN;
        else
        begin
            // walk the deeper-indexed node upwards until both meet
            a = map_node[r.first_block];
            b = map_node[r.second_block];
            guard = 0;
            while (a != b && guard < 2 * NODE_SLOTS)
            begin
                if (a > b)
                    a = tree_parent[a];
                else
                    b = tree_parent[b];
                guard++;
            end
            res.ancestor_block = tree_block[a];
        end
        return res;
    endfunction

    // append a request and track which blocks it should create
    task automatic queue_request(logic op, logic [7:0] a, logic [7:0] b, bit drain);
        pending_t item;
        item.payload.operation    = op;
        item.payload.first_block  = a;
        item.payload.second_block = b;
        item.drain_first          = drain;
        pending_reqs.push_back(item);
        if (op == OP_ADD)
        begin
            if (gen_nodes == 0)
            begin
                gen_nodes    = 1;
                gen_known[0] = 1'b1;
                gen_known_list.push_back(8'd0);
            end
            if (a != b && gen_known[a] && gen_nodes < NODE_SLOTS)
            begin
                if (!gen_known[b])
                    gen_known_list.push_back(b);
                gen_known[b]   = 1'b1;
                gen_nodes      = gen_nodes + 1;
                gen_last_child = b;
            end
        end
    endtask

    function automatic logic [7:0] any_known();
        return gen_known_list[$urandom_range(0, gen_known_list.size() - 1)];
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                lca_expected.push_back(lca_predict(req));
                sent_count++;
                // some stretches run without gaps
                drive_gap = ((sent_count / 50) % 4 == 2) ? 0 : $urandom_range(0, 6);
            end
            if (!req_valid || req_ready)
            begin
                if (drive_gap > 0)
                begin
                    drive_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].drain_first || lca_expected.size() == 0))
                begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs[0].payload;
                    void'(pending_reqs.pop_front());
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                got_count++;
                if (lca_expected.size() == 0)
                begin
                    $error("unexpected response: ancestor_block %0d, status %0d",
                           rsp.ancestor_block, rsp.status);
                    mismatch_count++;
                end
                else
                begin
                    if (rsp.ancestor_block !== lca_expected[0].ancestor_block)
                    begin
                        $error("ancestor_block mismatch: expected %0d, actual %0d",
                               lca_expected[0].ancestor_block, rsp.ancestor_block);
                        mismatch_count++;
                    end
                    if (rsp.status !== lca_expected[0].status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               lca_expected[0].status, rsp.status);
                        mismatch_count++;
                    end
                    void'(lca_expected.pop_front());
                end
                // one long hold-off so the engine backs up into its input
                if (got_count == LONG_HOLD_AT)
                    hold_left = LONG_HOLD;
                else
                    hold_left = ((got_count / 50) % 4 == 3) ? 0 : $urandom_range(0, 6);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int         r;
        logic [7:0] a;
        logic [7:0] b;

        // directed: empty table, root creation on a failing add, small tree
        queue_request(OP_QUERY, 8'd0,   8'd0,   1'b0);
        queue_request(OP_ADD,   8'd7,   8'd7,   1'b0);
        queue_request(OP_QUERY, 8'd0,   8'd0,   1'b0);
        queue_request(OP_ADD,   8'd0,   8'd1,   1'b0);
        queue_request(OP_ADD,   8'd1,   8'd2,   1'b0);
        queue_request(OP_ADD,   8'd2,   8'd3,   1'b0);
        queue_request(OP_ADD,   8'd0,   8'd4,   1'b0);
        queue_request(OP_ADD,   8'd4,   8'd255, 1'b0);
        queue_request(OP_ADD,   8'd9,   8'd10,  1'b0);
        queue_request(OP_ADD,   8'd255, 8'd128, 1'b0);
        queue_request(OP_ADD,   8'd3,   8'd3,   1'b0);
        // same-block check wins over the unknown parent
        queue_request(OP_ADD,   8'd200, 8'd200, 1'b0);
        queue_request(OP_QUERY, 8'd3,   8'd255, 1'b1);
        queue_request(OP_QUERY, 8'd2,   8'd3,   1'b0);
        queue_request(OP_QUERY, 8'd3,   8'd3,   1'b0);
        queue_request(OP_QUERY, 8'd128, 8'd255, 1'b0);
        queue_request(OP_QUERY, 8'd7,   8'd1,   1'b0);
        queue_request(OP_QUERY, 8'd1,   8'd7,   1'b0);
        queue_request(OP_QUERY, 8'd255, 8'd255, 1'b0);
        // remap block 1 below block 3
        queue_request(OP_ADD,   8'd3,   8'd1,   1'b0);
        queue_request(OP_QUERY, 8'd2,   8'd1,   1'b0);
        queue_request(OP_QUERY, 8'd1,   8'd4,   1'b0);
        queue_request(OP_QUERY, 8'd0,   8'd128, 1'b0);

        // random: grow a deep tree first, then mostly queries on the full one
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (gen_nodes < NODE_SLOTS)
            begin
                if (r < 75)
                begin
                    a = (r < 40) ? gen_last_child : any_known();
                    queue_request(OP_ADD, a, 8'($urandom_range(0, 255)), i % 100 == 99);
                end
                else if (r < 88)
                begin
                    a = 8'($urandom_range(0, 255));
                    b = (r < 80) ? a : 8'($urandom_range(0, 255));
                    queue_request(OP_ADD, a, b, i % 100 == 99);
                end
                else
                    queue_request(OP_QUERY, any_known(), any_known(), i % 100 == 99);
            end
            else
            begin
                if (r < 70)
                    queue_request(OP_QUERY, any_known(), any_known(), i % 100 == 99);
                else if (r < 85)
                begin
                    a = 8'($urandom_range(0, 255));
                    if (r < 78)
                        queue_request(OP_QUERY, a, any_known(), i % 100 == 99);
                    else
                        queue_request(OP_QUERY, any_known(), a, i % 100 == 99);
                end
                else if (r < 95)
                    queue_request(OP_ADD, any_known(), 8'($urandom_range(0, 255)),
                                  i % 100 == 99);
                else
                begin
                    a = 8'($urandom_range(0, 255));
                    queue_request(OP_ADD, a, a, i % 100 == 99);
                end
            end
        end
        total_reqs = pending_reqs.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_reqs || lca_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && lca_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
